// ===== hdl/torque_slew_clamp_watchdog_macros.svh =====
// Assertion macros for the torque slew clamp watchdog
`ifndef TORQUE_SLEW_CLAMP_WATCHDOG_MACROS_SVH
`define TORQUE_SLEW_CLAMP_WATCHDOG_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define TSCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TSCW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSCW_ASSERT_IMP(lbl, ante, cons, msg)
`define TSCW_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/tscw_pkg.sv =====
// Shared types and constants for the torque slew clamp watchdog
package tscw_pkg;

  localparam int JOINTS_DEF       = 7;
  localparam int LARGE_JOINTS_DEF = 4;
  localparam int TORQUE_BITS_DEF  = 18;

  localparam int LIMIT_BITS = 18;
  localparam int SLEW_BITS  = 16;
  localparam int DT_BITS    = 16;
  localparam int AGE_BITS   = 24;
  localparam int CFG_BITS   = 24;
  localparam int CFG_IDX_BITS = 3;

  // slew_rate * dt_us and its quotient by 1000
  localparam int PROD_BITS = SLEW_BITS + DT_BITS;
  localparam int MC_BITS   = 23;
  // floor(p / 1000) == (p * RECIP_MAGIC) >> RECIP_SHIFT for every 32-bit p
  localparam int RECIP_BITS  = 29;
  localparam int RECIP_SHIFT = 38;
  localparam logic [RECIP_BITS-1:0] RECIP_MAGIC = 29'h10624DD3;

  localparam logic signed [LIMIT_BITS-1:0] UPPER_MAX_RST = 18'sd87000;
  localparam logic signed [LIMIT_BITS-1:0] UPPER_MIN_RST = -18'sd87000;
  localparam logic signed [LIMIT_BITS-1:0] LOWER_MAX_RST = 18'sd12000;
  localparam logic signed [LIMIT_BITS-1:0] LOWER_MIN_RST = -18'sd12000;
  localparam logic [SLEW_BITS-1:0] SLEW_RST    = 16'd1000;
  localparam logic [AGE_BITS-1:0]  TIMEOUT_RST = 24'd500000;
  localparam logic [AGE_BITS-1:0]  AGE_MAX     = '1;

  typedef enum logic {
    KIND_CMD  = 1'b0,
    KIND_TICK = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_UPPER_MAX = 3'd0,
    CFG_UPPER_MIN = 3'd1,
    CFG_LOWER_MAX = 3'd2,
    CFG_LOWER_MIN = 3'd3,
    CFG_SLEW      = 3'd4,
    CFG_TIMEOUT   = 3'd5
  } cfg_idx_t;

  // pipeline advance strobes for the slew divider
  typedef struct packed {
    logic load1;
    logic load2;
  } tscw_adv_t;

  // per-tick controls shared by all lanes
  typedef struct packed {
    logic states_valid;
    logic slew_en;
    logic timed_out;
  } tscw_lane_ctl_t;

  typedef struct packed {
    logic signed [LIMIT_BITS-1:0] lo;
    logic signed [LIMIT_BITS-1:0] hi;
  } tscw_lim_t;

endpackage

// ===== hdl/tscw_in_if.sv =====
// Input channel: torque commands and control ticks
interface tscw_in_if #(
  parameter int JOINTS      = tscw_pkg::JOINTS_DEF,
  parameter int TORQUE_BITS = tscw_pkg::TORQUE_BITS_DEF
);
  import tscw_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [TORQUE_BITS-1:0] torque_j [JOINTS];
  logic [DT_BITS-1:0]            dt_us;
  logic                          states_valid;

  modport source (output valid, kind, torque_j, dt_us, states_valid, input ready);
  modport sink   (input valid, kind, torque_j, dt_us, states_valid, output ready);
endinterface

// ===== hdl/tscw_out_if.sv =====
// Result channel: commanded torques and status flags
interface tscw_out_if #(
  parameter int JOINTS      = tscw_pkg::JOINTS_DEF,
  parameter int TORQUE_BITS = tscw_pkg::TORQUE_BITS_DEF
);
  import tscw_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [TORQUE_BITS-1:0] out_j [JOINTS];
  logic                          timed_out;
  logic                          any_clamped;

  modport source (output valid, out_j, timed_out, any_clamped, input ready);
  modport sink   (input valid, out_j, timed_out, any_clamped, output ready);
endinterface

// ===== hdl/tscw_slew_div.sv =====
// Two-stage slew-step unit: slew_rate * dt_us, then divide by 1000
module tscw_slew_div (
  input  logic                          clk,
  input  tscw_pkg::tscw_adv_t           adv,
  input  logic [tscw_pkg::SLEW_BITS-1:0] slew_rate,
  input  logic [tscw_pkg::DT_BITS-1:0]  dt_us,
  output logic [tscw_pkg::MC_BITS-1:0]  slew_step
);
  import tscw_pkg::*;

  localparam int FULL_BITS = PROD_BITS + RECIP_BITS;

  logic [PROD_BITS-1:0] prod_r;
  logic [MC_BITS-1:0]   mc_r;
  logic [FULL_BITS-1:0] scaled;

  // reciprocal multiply; magic constant is exact over the full 32-bit range
  assign scaled = FULL_BITS'(prod_r) * FULL_BITS'(RECIP_MAGIC);

  always_ff @(posedge clk) begin
    if (adv.load1) begin
      prod_r <= PROD_BITS'(slew_rate) * PROD_BITS'(dt_us);
    end
    if (adv.load2) begin
      mc_r <= scaled[RECIP_SHIFT +: MC_BITS];
    end
  end

  assign slew_step = mc_r;
endmodule

// ===== hdl/tscw_lane.sv =====
// One joint lane: slew limit, group clamp, saturation, timeout zeroing
module tscw_lane #(
  parameter int TORQUE_BITS = tscw_pkg::TORQUE_BITS_DEF
) (
  input  logic signed [TORQUE_BITS-1:0] desired,
  input  logic signed [TORQUE_BITS-1:0] prev,
  input  logic [tscw_pkg::MC_BITS-1:0]  slew_step,
  input  tscw_pkg::tscw_lim_t           lim,
  input  tscw_pkg::tscw_lane_ctl_t      ctl,
  output logic signed [TORQUE_BITS-1:0] result,
  output logic                          clamped
);
  import tscw_pkg::*;

  localparam int W0 = (TORQUE_BITS > LIMIT_BITS) ? TORQUE_BITS : LIMIT_BITS;
  localparam int W1 = (W0 > MC_BITS + 1) ? W0 : MC_BITS + 1;
  localparam int LW = W1 + 2;
  localparam logic signed [LW-1:0] TMAX = LW'((64'sd1 <<< (TORQUE_BITS - 1)) - 64'sd1);
  localparam logic signed [LW-1:0] TMIN = -TMAX - LW'(1);

  logic signed [LW-1:0] v0, p, mc, d, v1, lo, hi, c;

  always_comb begin
    p  = LW'(prev);
    v0 = ctl.states_valid ? LW'(desired) : '0;
    mc = LW'(signed'({1'b0, slew_step}));
    lo = LW'(lim.lo);
    hi = LW'(lim.hi);
    d  = v0 - p;
    v1 = v0;
    if (ctl.slew_en) begin
      if (d > mc) begin
        v1 = p + mc;
      end else if (d < -mc) begin
        v1 = p - mc;
      end
    end
    // lo is checked before hi, which matters when the limits cross
    if (v1 < lo) begin
      c = lo;
    end else if (hi < v1) begin
      c = hi;
    end else begin
      c = v1;
    end
    clamped = (c != v1);
    if (c > TMAX) begin
      c = TMAX;
    end else if (c < TMIN) begin
      c = TMIN;
    end
    result = ctl.timed_out ? '0 : TORQUE_BITS'(c);
  end
endmodule

// ===== hdl/torque_slew_clamp_watchdog.sv =====
// Top level: input pipeline, per-joint lanes, merge and result register
// Tick path: v1_r stage, v2_r stage, result register, then result valid.
// Throughput: one item per cycle unless out_ch.ready stalls; the lane stage reads
//   and writes the previous outputs in the same cycle and so sets the rate.
// Commands produce no result and only update desired torques and command age.
// Reset (rst_n low, synchronous): limits, slew rate and timeout return to
//   defaults; desired torques, previous outputs, command age and pipeline clear.
`include "torque_slew_clamp_watchdog_macros.svh"
module torque_slew_clamp_watchdog #(
  parameter int JOINTS       = tscw_pkg::JOINTS_DEF,
  parameter int LARGE_JOINTS = tscw_pkg::LARGE_JOINTS_DEF,
  parameter int TORQUE_BITS  = tscw_pkg::TORQUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  tscw_in_if.sink                           in_ch,
  tscw_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [tscw_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [tscw_pkg::CFG_BITS-1:0]     cfg_wdata
);
  import tscw_pkg::*;

  // configuration
  logic signed [LIMIT_BITS-1:0] upper_max_r, upper_min_r, lower_max_r, lower_min_r;
  logic [SLEW_BITS-1:0]         slew_r;
  logic [AGE_BITS-1:0]          timeout_r;

  // block state
  logic signed [TORQUE_BITS-1:0] desired_r [JOINTS];
  logic signed [TORQUE_BITS-1:0] prev_r    [JOINTS];
  logic [AGE_BITS-1:0]           age_r;

  // pipeline stages
  logic                          v1_r, v2_r;
  logic                          kind1_r, kind2_r;
  logic signed [TORQUE_BITS-1:0] tq1_r [JOINTS];
  logic signed [TORQUE_BITS-1:0] tq2_r [JOINTS];
  logic [DT_BITS-1:0]            dt1_r, dt2_r;
  logic                          sv1_r, sv2_r;

  // result register
  logic                          out_valid_r;
  logic signed [TORQUE_BITS-1:0] out_j_r [JOINTS];
  logic                          out_to_r, out_cl_r;

  logic           can_out, go2, rdy2, go1, in_ready, accept;
  tscw_adv_t      adv;
  logic [MC_BITS-1:0] slew_step;
  logic [AGE_BITS:0]  age_sum;
  logic [AGE_BITS-1:0] age_nxt;
  logic           timed_out;
  tscw_lane_ctl_t lane_ctl;
  tscw_lim_t      lim_upper, lim_lower;
  logic signed [TORQUE_BITS-1:0] lane_res [JOINTS];
  logic [JOINTS-1:0] lane_clamp;
  logic           out_zero;

  // handshake chain; a command leaves the lane stage without a result slot
  assign can_out  = !out_valid_r || out_ch.ready;
  assign go2      = v2_r && ((kind2_r == KIND_CMD) || can_out);
  assign rdy2     = !v2_r || go2;
  assign go1      = v1_r && rdy2;
  assign in_ready = !v1_r || go1;
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign adv.load1 = accept;
  assign adv.load2 = go1;

  tscw_slew_div u_div (
    .clk       (clk),
    .adv       (adv),
    .slew_rate (slew_r),
    .dt_us     (in_ch.dt_us),
    .slew_step (slew_step)
  );

  assign age_sum   = {1'b0, age_r} + (AGE_BITS + 1)'(dt2_r);
  assign age_nxt   = age_sum[AGE_BITS] ? AGE_MAX : age_sum[AGE_BITS-1:0];
  assign timed_out = age_nxt > timeout_r;

  assign lane_ctl.states_valid = sv2_r;
  assign lane_ctl.slew_en      = |dt2_r;
  assign lane_ctl.timed_out    = timed_out;
  assign lim_upper.lo = upper_min_r;
  assign lim_upper.hi = upper_max_r;
  assign lim_lower.lo = lower_min_r;
  assign lim_lower.hi = lower_max_r;

  for (genvar g = 0; g < JOINTS; g++) begin : g_lane
    tscw_lane #(.TORQUE_BITS(TORQUE_BITS)) u_lane (
      .desired   (desired_r[g]),
      .prev      (prev_r[g]),
      .slew_step (slew_step),
      .lim       ((g < LARGE_JOINTS) ? lim_upper : lim_lower),
      .ctl       (lane_ctl),
      .result    (lane_res[g]),
      .clamped   (lane_clamp[g])
    );
  end

  // config and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_max_r <= UPPER_MAX_RST;
      upper_min_r <= UPPER_MIN_RST;
      lower_max_r <= LOWER_MAX_RST;
      lower_min_r <= LOWER_MIN_RST;
      slew_r      <= SLEW_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UPPER_MAX: upper_max_r <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_UPPER_MIN: upper_min_r <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_LOWER_MAX: lower_max_r <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_LOWER_MIN: lower_min_r <= cfg_wdata[LIMIT_BITS-1:0];
        CFG_SLEW:      slew_r      <= cfg_wdata[SLEW_BITS-1:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_wdata[AGE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      age_r       <= '0;
      for (int j = 0; j < JOINTS; j++) begin
        desired_r[j] <= '0;
        prev_r[j]    <= '0;
      end
    end else begin
      if (accept) begin
        v1_r <= 1'b1;
      end else if (go1) begin
        v1_r <= 1'b0;
      end
      if (go1) begin
        v2_r <= 1'b1;
      end else if (go2) begin
        v2_r <= 1'b0;
      end
      if (go2 && (kind2_r == KIND_TICK)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (go2) begin
        if (kind2_r == KIND_CMD) begin
          desired_r <= tq2_r;
          age_r     <= '0;
        end else begin
          prev_r <= lane_res;
          age_r  <= age_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind1_r <= in_ch.kind;
      tq1_r   <= in_ch.torque_j;
      dt1_r   <= in_ch.dt_us;
      sv1_r   <= in_ch.states_valid;
    end
    if (go1) begin
      kind2_r <= kind1_r;
      tq2_r   <= tq1_r;
      dt2_r   <= dt1_r;
      sv2_r   <= sv1_r;
    end
    if (go2 && (kind2_r == KIND_TICK)) begin
      out_j_r  <= lane_res;
      out_to_r <= timed_out;
      out_cl_r <= |lane_clamp;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_j       = out_j_r;
  assign out_ch.timed_out   = out_to_r;
  assign out_ch.any_clamped = out_cl_r;

  always_comb begin
    out_zero = 1'b1;
    for (int j = 0; j < JOINTS; j++) begin
      out_zero = out_zero && (out_j_r[j] == '0);
    end
  end

  `TSCW_ASSERT_NXT(a_tick_gives_result, go2 && (kind2_r == KIND_TICK), out_valid_r, "tick transaction lost its result")
  `TSCW_ASSERT_NXT(a_cmd_clears_age, go2 && (kind2_r == KIND_CMD), age_r == '0, "command did not clear age")
  `TSCW_ASSERT_IMP(a_stall_only_when_full, !in_ready, v1_r && v2_r && out_valid_r, "input stalled with room in pipeline")
  `TSCW_ASSERT_IMP(a_timeout_zeroes, out_valid_r && out_to_r, out_zero, "timed out result not zero")
endmodule
